### src/ssd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ssd_pkg;

  // Number of digit positions in the display
  localparam int DIGITS = 4;
  localparam int DIGIT_W = $clog2(DIGITS);

  localparam logic [7:0] POINT_BIT = 8'b1000_0000;
  localparam int GLYPH_COUNT = 23;
  localparam logic [9:0] NUMBER_LIMIT = 10'd1000;

  // Command codes
  typedef enum logic [2:0] {
    FUNC_DECIMAL = 3'd0,
    FUNC_GLYPH   = 3'd1,
    FUNC_POINT   = 3'd2,
    FUNC_CLEAR   = 3'd3,
    FUNC_NUMBER  = 3'd4,
    FUNC_VERSION = 3'd5,
    FUNC_SCAN    = 3'd6,
    FUNC_READ    = 3'd7
  } ssd_func_t;

  // Decimal places of a 10-bit value, plus low quotient bits and range flags
  typedef struct packed {
    logic [3:0] hund;
    logic [3:0] tens;
    logic [3:0] units;
    logic [3:0] q10_low;
    logic       q10_small;
    logic       below_limit;
  } ssd_split_t;

  // Segment pattern for glyph index; indices past the table give blank
  function automatic logic [7:0] glyph_rom(input logic [4:0] idx);
    logic [7:0] pat;
    unique case (idx)
      5'd0:    pat = 8'h3F;
      5'd1:    pat = 8'h06;
      5'd2:    pat = 8'h5B;
      5'd3:    pat = 8'h4F;
      5'd4:    pat = 8'h66;
      5'd5:    pat = 8'h6D;
      5'd6:    pat = 8'h7D;
      5'd7:    pat = 8'h07;
      5'd8:    pat = 8'h7F;
      5'd9:    pat = 8'h6F;
      5'd10:   pat = 8'h77;
      5'd11:   pat = 8'h7C;
      5'd12:   pat = 8'h58;
      5'd13:   pat = 8'h5E;
      5'd14:   pat = 8'h79;
      5'd15:   pat = 8'h71;
      5'd16:   pat = 8'h00;
      5'd17:   pat = 8'h40;
      5'd18:   pat = 8'h08;
      5'd19:   pat = 8'h01;
      5'd20:   pat = 8'h36;
      5'd21:   pat = 8'h78;
      5'd22:   pat = 8'h73;
      default: pat = 8'h00;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

### src/ssd_split.sv
`timescale 1ns / 1ps
`default_nettype none

module ssd_split
  import ssd_pkg::*;
(
  input  wire logic [9:0] value,
  output ssd_split_t      parts
);

  logic [17:0] p10;
  logic [6:0]  q10;
  logic [13:0] p100;
  logic [3:0]  q100;
  logic [9:0]  units_full;
  logic [6:0]  tens_full;

  // Divide by ten through the reciprocal 205/2048, exact below 1029
  assign p10 = 18'(value) * 18'd205;
  assign q10 = p10[17:11];

  // Divide the quotient by ten again through 103/1024, exact below 179
  assign p100 = 14'(q10) * 14'd103;
  assign q100 = p100[13:10];

  // Take remainders back out
  assign units_full = value - 10'(q10) * 10'd10;
  assign tens_full  = q10 - 7'(q100) * 7'd10;

  assign parts.hund        = q100;
  assign parts.tens        = tens_full[3:0];
  assign parts.units       = units_full[3:0];
  assign parts.q10_low     = q10[3:0];
  assign parts.q10_small   = (q10 < 7'd10);
  assign parts.below_limit = (value < NUMBER_LIMIT);

endmodule

`default_nettype wire

### src/seven_segment_display_controller.sv
`timescale 1ns / 1ps
`default_nettype none

// Multiplexed seven-segment driver. A request is taken on every clock edge
// at which start is high (busy is never raised), and its result appears on
// the out_ ports with out_valid high in the next cycle, for one cycle
// only: the receiver has no way to hold it back, so capture it then. The
// whole command is decoded and applied between the input ports and the
// result register in one pass. out_scan_digit follows the scan index at all
// times; the segment outputs are meaningful only while out_valid is high.

module seven_segment_display_controller
  import ssd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [2:0] in_func,
  input  wire logic [1:0] in_digit,
  input  wire logic [9:0] in_value,
  input  wire logic [3:0] in_major,
  output logic            out_valid,
  output logic [1:0]      out_scan_digit,
  output logic [7:0]      out_scan_segments,
  output logic [7:0]      out_read_segments
);

  localparam logic [DIGIT_W-1:0] TOP = DIGIT_W'(DIGITS - 1);
  localparam logic [DIGIT_W-1:0] MID = DIGIT_W'(DIGITS - 2);
  localparam logic [DIGIT_W-1:0] LOW = DIGIT_W'(DIGITS - 3);

  logic [7:0]         seg_r   [DIGITS];
  logic [7:0]         seg_nxt [DIGITS];
  logic [DIGIT_W-1:0] scan_r, scan_nxt;
  logic               valid_r;
  logic [7:0]         scan_seg_r, read_seg_r;
  logic [7:0]         scan_seg_nxt, read_seg_nxt;
  ssd_split_t         parts;
  ssd_func_t          func;

  assign func = ssd_func_t'(in_func);
  assign busy = 1'b0;

  ssd_split u_split (
    .value (in_value),
    .parts (parts)
  );

  // Apply the command to the buffer and scan index
  always_comb begin
    seg_nxt  = seg_r;
    scan_nxt = scan_r;
    if (start) begin
      unique case (func)
        FUNC_DECIMAL: begin
          if (in_value < 10'd10) seg_nxt[in_digit] = glyph_rom(in_value[4:0]);
        end
        FUNC_GLYPH: begin
          if (in_value < 10'(GLYPH_COUNT)) seg_nxt[in_digit] = glyph_rom(in_value[4:0]);
        end
        FUNC_POINT: begin
          if (in_value != '0) seg_nxt[in_digit] = seg_r[in_digit] | POINT_BIT;
          else                seg_nxt[in_digit] = seg_r[in_digit] & ~POINT_BIT;
        end
        FUNC_CLEAR: begin
          for (int i = 0; i < DIGITS; i++) seg_nxt[i] = '0;
        end
        FUNC_NUMBER: begin
          if (parts.below_limit) begin
            seg_nxt[TOP] = glyph_rom({1'b0, parts.hund});
            seg_nxt[MID] = glyph_rom({1'b0, parts.tens});
            seg_nxt[LOW] = glyph_rom({1'b0, parts.units});
          end
        end
        FUNC_VERSION: begin
          if (in_major < 4'd10) seg_nxt[TOP] = glyph_rom({1'b0, in_major}) | POINT_BIT;
          else                  seg_nxt[TOP] = seg_r[TOP] | POINT_BIT;
          if (parts.q10_small) seg_nxt[MID] = glyph_rom({1'b0, parts.q10_low});
          seg_nxt[LOW] = glyph_rom({1'b0, parts.units});
        end
        FUNC_SCAN: begin
          scan_nxt = (scan_r == TOP) ? '0 : scan_r + 1'b1;
        end
        FUNC_READ: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Pick the bytes reported for this request
  assign scan_seg_nxt = seg_nxt[scan_nxt];
  assign read_seg_nxt = seg_nxt[in_digit];

  // Hold buffer and scan state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIGITS; i++) seg_r[i] <= '0;
      scan_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      seg_r   <= seg_nxt;
      scan_r  <= scan_nxt;
      valid_r <= start;
    end
  end

  // Capture the result payload
  always_ff @(posedge clk) begin
    if (start) begin
      scan_seg_r <= scan_seg_nxt;
      read_seg_r <= read_seg_nxt;
    end
  end

  assign out_valid         = valid_r;
  assign out_scan_digit    = 2'(scan_r);
  assign out_scan_segments = scan_seg_r;
  assign out_read_segments = read_seg_r;

endmodule

`default_nettype wire

### src/ssd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ssd_checker
  import ssd_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [2:0] in_func,
  input wire logic       out_valid,
  input wire logic [1:0] out_scan_digit,
  input wire logic [7:0] out_scan_segments,
  input wire logic [7:0] out_read_segments
);

  // Every request gives exactly one result on the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (out_valid == $past(start && !busy)))
    else $error("result strobe does not follow request");

  // Only a scan tick moves the scan
  a_scan_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!(start && !busy) || in_func != FUNC_SCAN) |=> $stable(out_scan_digit))
    else $error("scan digit moved without a tick");

  // A scan tick advances the scan by one position
  a_scan_step: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_func == FUNC_SCAN) |=>
      (out_scan_digit == ((32'($past(out_scan_digit)) + 1) % DIGITS)))
    else $error("scan tick did not advance the scan");

  // A clear leaves both reported bytes blank
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_func == FUNC_CLEAR) |=>
      (out_scan_segments == 8'h00 && out_read_segments == 8'h00))
    else $error("clear left segments lit");

endmodule

bind seven_segment_display_controller ssd_checker u_ssd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .in_func           (in_func),
  .out_valid         (out_valid),
  .out_scan_digit    (out_scan_digit),
  .out_scan_segments (out_scan_segments),
  .out_read_segments (out_read_segments)
);

`default_nettype wire
